// ----- sv/dcf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and codes of the DCF77 time code decoder: item structs,
// operation and status codes, register map and reset values.
// ----------------------------------------------------------------------------
package dcf_pkg;

    localparam int FRAME_LEN  = 60;
    localparam int NUM_REGS   = 7;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // operation codes of an input item
    localparam logic [1:0] OP_PULSE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // status codes of a result item
    localparam logic [3:0] ST_STARTED = 4'd0;
    localparam logic [3:0] ST_ZERO    = 4'd1;
    localparam logic [3:0] ST_ONE     = 4'd2;
    localparam logic [3:0] ST_MARKER  = 4'd3;
    localparam logic [3:0] ST_BAD     = 4'd4;
    localparam logic [3:0] ST_TIMEOUT = 4'd5;
    localparam logic [3:0] ST_OK      = 4'd6;
    localparam logic [3:0] ST_PARITY  = 4'd7;
    localparam logic [3:0] ST_RANGE   = 4'd8;
    localparam logic [3:0] ST_NOTHING = 4'd9;

    // register indexes
    localparam logic [2:0] REG_ZERO_LOW    = 3'd0;
    localparam logic [2:0] REG_ZERO_HIGH   = 3'd1;
    localparam logic [2:0] REG_ONE_LOW     = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH    = 3'd3;
    localparam logic [2:0] REG_MARKER_LOW  = 3'd4;
    localparam logic [2:0] REG_MARKER_HIGH = 3'd5;
    localparam logic [2:0] REG_TIMEOUT     = 3'd6;

    // register reset values
    localparam logic [15:0] RST_ZERO_LOW    = 16'd70;
    localparam logic [15:0] RST_ZERO_HIGH   = 16'd150;
    localparam logic [15:0] RST_ONE_LOW     = 16'd170;
    localparam logic [15:0] RST_ONE_HIGH    = 16'd280;
    localparam logic [15:0] RST_MARKER_LOW  = 16'd450;
    localparam logic [15:0] RST_MARKER_HIGH = 16'd700;
    localparam logic [15:0] RST_TIMEOUT     = 16'd800;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pulse_ms;
    } t_in;

    typedef struct packed {
        logic [3:0] status;
        logic       receiving;
        logic [5:0] bit_count;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
        logic [2:0] weekday;
    } t_out;

    typedef struct packed {
        logic [15:0] zero_low_ms;
        logic [15:0] zero_high_ms;
        logic [15:0] one_low_ms;
        logic [15:0] one_high_ms;
        logic [15:0] marker_low_ms;
        logic [15:0] marker_high_ms;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // one classified item on its way from the front to the back
    typedef struct packed {
        logic                 decode;
        logic [3:0]           status;
        logic                 receiving;
        logic [5:0]           bit_count;
        logic [FRAME_LEN-1:0] frame;
    } t_job;

endpackage

// ----- sv/dcf77_time_code_decoder.sv -----
// ----------------------------------------------------------------------------
// dcf77_time_code_decoder
// Decodes DCF77 time frames from measured pulse widths, ticks and starts.
// ----------------------------------------------------------------------------
// Input channel (i_valid, o_stall, i_data): one item per command: a pulse
// width, a timeout tick or a start request. Output channel (o_valid, i_stall,
// o_data): exactly one result item per input item, in order.
// The window and timeout registers sit on the APB port at byte address 4*i;
// write them only while the block is idle.
// A plain item passes through the job queue and the output register on its way,
// and items are taken one per cycle while the two-entry job queue has room.
// An item that completes a 60-position frame is loaded into the decode unit,
// which walks the stored frame bits one per cycle and then reports the
// result; items behind it wait in the queue, and o_stall rises once the
// queue is full.
// When the receiver stalls, the output register holds its item, the queue
// fills, and then the input stalls. Reset returns the registers to their
// default windows, clears the reception state and empties the queue.
// ----------------------------------------------------------------------------
module dcf77_time_code_decoder import dcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;
    logic       q_full;
    logic       q_valid;
    logic       push;
    logic       pop;
    t_job       push_job;
    t_job       head_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_low_ms    <= RST_ZERO_LOW;
            r_cfg.zero_high_ms   <= RST_ZERO_HIGH;
            r_cfg.one_low_ms     <= RST_ONE_LOW;
            r_cfg.one_high_ms    <= RST_ONE_HIGH;
            r_cfg.marker_low_ms  <= RST_MARKER_LOW;
            r_cfg.marker_high_ms <= RST_MARKER_HIGH;
            r_cfg.timeout_ticks  <= RST_TIMEOUT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ZERO_LOW:    r_cfg.zero_low_ms    <= pwdata[15:0];
                REG_ZERO_HIGH:   r_cfg.zero_high_ms   <= pwdata[15:0];
                REG_ONE_LOW:     r_cfg.one_low_ms     <= pwdata[15:0];
                REG_ONE_HIGH:    r_cfg.one_high_ms    <= pwdata[15:0];
                REG_MARKER_LOW:  r_cfg.marker_low_ms  <= pwdata[15:0];
                REG_MARKER_HIGH: r_cfg.marker_high_ms <= pwdata[15:0];
                REG_TIMEOUT:     r_cfg.timeout_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ZERO_LOW:    prdata = {16'd0, r_cfg.zero_low_ms};
            REG_ZERO_HIGH:   prdata = {16'd0, r_cfg.zero_high_ms};
            REG_ONE_LOW:     prdata = {16'd0, r_cfg.one_low_ms};
            REG_ONE_HIGH:    prdata = {16'd0, r_cfg.one_high_ms};
            REG_MARKER_LOW:  prdata = {16'd0, r_cfg.marker_low_ms};
            REG_MARKER_HIGH: prdata = {16'd0, r_cfg.marker_high_ms};
            REG_TIMEOUT:     prdata = {16'd0, r_cfg.timeout_ticks};
            default:         prdata = '0;
        endcase
    end

    dcf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    dcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    dcf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

// ----- sv/dcf_front.sv -----
// ----------------------------------------------------------------------------
// dcf_front
// Accepts input items, classifies pulses against the configured windows,
// keeps the reception state and the frame shift line, and emits one job per
// item.
// ----------------------------------------------------------------------------
module dcf_front import dcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    input  logic i_q_full,
    output logic o_push,
    output t_job o_job
);

    logic                 r_rx;
    logic [5:0]           r_fill;
    logic [15:0]          r_ticks;
    logic [FRAME_LEN-1:0] r_frame;

    logic                 n_rx;
    logic [5:0]           n_fill;
    logic [15:0]          n_ticks;
    logic [FRAME_LEN-1:0] n_frame;
    logic [3:0]           n_status;
    logic                 n_decode;

    logic in_marker, in_one, in_zero;
    logic [15:0] tick_inc;

    assign in_marker = (i_data.pulse_ms > i_cfg.marker_low_ms)
                    && (i_data.pulse_ms < i_cfg.marker_high_ms);
    assign in_one    = (i_data.pulse_ms > i_cfg.one_low_ms)
                    && (i_data.pulse_ms < i_cfg.one_high_ms);
    assign in_zero   = (i_data.pulse_ms > i_cfg.zero_low_ms)
                    && (i_data.pulse_ms < i_cfg.zero_high_ms);
    assign tick_inc  = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;

    always_comb begin
        n_rx     = r_rx;
        n_fill   = r_fill;
        n_ticks  = r_ticks;
        n_frame  = r_frame;
        n_status = ST_NOTHING;
        n_decode = 1'b0;
        unique case (i_data.op)
            OP_START: begin
                if (!r_rx) begin
                    n_rx     = 1'b1;
                    n_ticks  = '0;
                    n_fill   = '0;
                    n_status = ST_STARTED;
                end
            end
            OP_TICK: begin
                if (r_rx) begin
                    n_ticks = tick_inc;
                    if (tick_inc >= i_cfg.timeout_ticks) begin
                        n_rx     = 1'b0;
                        n_status = ST_TIMEOUT;
                    end
                end
            end
            OP_PULSE: begin
                if (r_rx) begin
                    // shift in at the top: after 60 entries position i sits at bit i
                    priority if (in_marker) begin
                        n_frame  = {1'b0, r_frame[FRAME_LEN-1:1]};
                        n_fill   = 6'd1;
                        n_status = ST_MARKER;
                    end else if (in_one) begin
                        if (r_fill < 6'(FRAME_LEN)) begin
                            n_frame = {1'b1, r_frame[FRAME_LEN-1:1]};
                            n_fill  = r_fill + 6'd1;
                        end
                        n_status = ST_ONE;
                    end else if (in_zero) begin
                        if (r_fill < 6'(FRAME_LEN)) begin
                            n_frame = {1'b0, r_frame[FRAME_LEN-1:1]};
                            n_fill  = r_fill + 6'd1;
                        end
                        n_status = ST_ZERO;
                    end else begin
                        n_rx     = 1'b0;
                        n_status = ST_BAD;
                    end
                    if (n_rx && (n_fill >= 6'(FRAME_LEN))) begin
                        n_rx     = 1'b0;
                        n_decode = 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_NOTHING;
            end
        endcase
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_job.decode    = n_decode;
        o_job.status    = n_status;
        o_job.receiving = n_rx;
        o_job.bit_count = n_fill;
        o_job.frame     = n_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx    <= 1'b0;
            r_fill  <= '0;
            r_ticks <= '0;
        end else if (o_push) begin
            r_rx    <= n_rx;
            r_fill  <= n_fill;
            r_ticks <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_frame <= n_frame;
        end
    end

endmodule

// ----- sv/dcf_queue.sv -----
// ----------------------------------------------------------------------------
// dcf_queue
// Two-entry job queue between the classifying front and the decoding back.
// ----------------------------------------------------------------------------
module dcf_queue import dcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- sv/dcf_back.sv -----
// ----------------------------------------------------------------------------
// dcf_back
// Takes jobs from the queue. Plain jobs go straight to the output register;
// a completed frame is walked one bit per cycle for parity and BCD fields,
// then checked and reported.
// ----------------------------------------------------------------------------
module dcf_back import dcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        F_NONE,
        F_MIN,
        F_HOUR,
        F_DAY,
        F_WDAY,
        F_MON,
        F_YEAR
    } t_fsel;

    t_state               r_state;
    logic                 r_out_valid;
    t_out                 r_out;
    logic [FRAME_LEN-1:0] r_frame;
    logic [5:0]           r_pos;
    logic [5:0]           r_cnt;
    logic [6:0]           r_min;
    logic [5:0]           r_hour;
    logic [5:0]           r_day;
    logic [4:0]           r_mon;
    logic [7:0]           r_year;
    logic [2:0]           r_wday;
    logic [2:0]           r_par;

    logic   out_free;
    logic   out_load;
    t_fsel  fsel;
    logic [7:0] weight;
    logic [2:0] pgrp;
    logic   par_fail;
    logic   range_fail;

    // field and BCD weight of a frame position
    function automatic t_fsel pos_field(input logic [5:0] pos);
        t_fsel f;
        f = F_NONE;
        if (pos >= 6'd21 && pos <= 6'd27) f = F_MIN;
        if (pos >= 6'd29 && pos <= 6'd34) f = F_HOUR;
        if (pos >= 6'd36 && pos <= 6'd41) f = F_DAY;
        if (pos >= 6'd42 && pos <= 6'd44) f = F_WDAY;
        if (pos >= 6'd45 && pos <= 6'd49) f = F_MON;
        if (pos >= 6'd50 && pos <= 6'd57) f = F_YEAR;
        return f;
    endfunction

    function automatic logic [7:0] pos_weight(input logic [5:0] pos);
        logic [7:0] w;
        logic [5:0] off;
        w   = 8'd0;
        off = 6'd0;
        priority if (pos >= 6'd21 && pos <= 6'd24) begin
            off = pos - 6'd21; w = 8'd1 << off[1:0];
        end else if (pos >= 6'd25 && pos <= 6'd27) begin
            off = pos - 6'd25; w = 8'd10 << off[1:0];
        end else if (pos >= 6'd29 && pos <= 6'd32) begin
            off = pos - 6'd29; w = 8'd1 << off[1:0];
        end else if (pos >= 6'd33 && pos <= 6'd34) begin
            off = pos - 6'd33; w = 8'd10 << off[1:0];
        end else if (pos >= 6'd36 && pos <= 6'd39) begin
            off = pos - 6'd36; w = 8'd1 << off[1:0];
        end else if (pos >= 6'd40 && pos <= 6'd41) begin
            off = pos - 6'd40; w = 8'd10 << off[1:0];
        end else if (pos >= 6'd42 && pos <= 6'd44) begin
            off = pos - 6'd42; w = 8'd1 << off[1:0];
        end else if (pos >= 6'd45 && pos <= 6'd48) begin
            off = pos - 6'd45; w = 8'd1 << off[1:0];
        end else if (pos == 6'd49) begin
            w = 8'd10;
        end else if (pos >= 6'd50 && pos <= 6'd53) begin
            off = pos - 6'd50; w = 8'd1 << off[1:0];
        end else if (pos >= 6'd54 && pos <= 6'd57) begin
            off = pos - 6'd54; w = 8'd10 << off[1:0];
        end else begin
            w = 8'd0;
        end
        return w;
    endfunction

    // parity group of a frame position: minute, hour, date
    function automatic logic [2:0] pos_parity(input logic [5:0] pos);
        logic [2:0] g;
        g = 3'b000;
        if (pos >= 6'd21 && pos <= 6'd28) g = 3'b001;
        if (pos >= 6'd29 && pos <= 6'd35) g = 3'b010;
        if (pos >= 6'd36 && pos <= 6'd58) g = 3'b100;
        return g;
    endfunction

    assign out_free   = !r_out_valid || !i_stall;
    assign fsel       = pos_field(r_pos);
    assign weight     = pos_weight(r_pos);
    assign pgrp       = pos_parity(r_pos);
    assign par_fail   = |r_par;
    assign range_fail = (r_min > 7'd59) || (r_hour > 6'd23) || (r_day > 6'd31)
                     || (r_mon > 5'd12) || (r_wday == 3'd0);

    assign o_pop    = (r_state == S_IDLE) && i_q_valid && (i_job.decode || out_free);
    assign out_load = (o_pop && !i_job.decode) || ((r_state == S_DONE) && out_free);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_job.decode) begin
                            r_frame <= i_job.frame;
                            r_cnt   <= i_job.bit_count;
                            r_pos   <= '0;
                            r_min   <= '0;
                            r_hour  <= '0;
                            r_day   <= '0;
                            r_mon   <= '0;
                            r_year  <= '0;
                            r_wday  <= '0;
                            r_par   <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_out <= '{i_job.status, i_job.receiving, i_job.bit_count,
                                       6'd0, 5'd0, 5'd0, 4'd0, 8'd0, 3'd0};
                        end
                    end
                end
                S_RUN: begin
                    // take one frame bit per cycle, lowest position first
                    if (r_frame[0]) begin
                        r_par <= r_par ^ pgrp;
                        unique case (fsel)
                            F_MIN:   r_min  <= r_min + weight[6:0];
                            F_HOUR:  r_hour <= r_hour + weight[5:0];
                            F_DAY:   r_day  <= r_day + weight[5:0];
                            F_WDAY:  r_wday <= r_wday + weight[2:0];
                            F_MON:   r_mon  <= r_mon + weight[4:0];
                            F_YEAR:  r_year <= r_year + weight;
                            default: ;
                        endcase
                    end
                    r_frame <= {1'b0, r_frame[FRAME_LEN-1:1]};
                    if (r_pos == 6'(FRAME_LEN - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pos <= r_pos + 6'd1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        priority if (par_fail) begin
                            r_out <= '{ST_PARITY, 1'b0, r_cnt,
                                       6'd0, 5'd0, 5'd0, 4'd0, 8'd0, 3'd0};
                        end else if (range_fail) begin
                            r_out <= '{ST_RANGE, 1'b0, r_cnt,
                                       6'd0, 5'd0, 5'd0, 4'd0, 8'd0, 3'd0};
                        end else begin
                            r_out <= '{ST_OK, 1'b0, r_cnt, r_min[5:0], r_hour[4:0],
                                       r_day[4:0], r_mon[3:0], r_year, r_wday};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- bench/dcf77_time_code_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcf77_time_code_decoder_tb
// Drives pulse, tick and start items into the decoder and checks every result
// item against a cycle-free model of the frame receiver. The run uses several
// window settings and random idle cycles on both channels.
// ----------------------------------------------------------------------------
module dcf77_time_code_decoder_tb;
    import dcf_pkg::*;

    localparam int CLK_HIGH     = 4;
    localparam int CLK_LOW      = 4;
    localparam int RESET_CYCLES = 3;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 80;
    localparam int IDLE_PCT     = 31;
    localparam int MAX_PRINTS   = 40;

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [15:0] TICK_MAX  = 16'hFFFF;

    typedef enum int {FRAME_GOOD, FRAME_PARITY, FRAME_RANGE, FRAME_RAW} t_frame_kind;

    // Tracks reception state and holds the result items still to arrive.
    class t_frame_scoreboard;
        t_cfg                 cfg;
        bit                   rx_on;
        bit [FRAME_LEN-1:0]   bits;
        bit [5:0]             fill;
        bit [15:0]            ticks;
        t_out                 awaited_reports[$];
        int                   errors;
        int                   reports_seen;
        int                   status_seen[16];

        function new();
            cfg = '{RST_ZERO_LOW, RST_ZERO_HIGH, RST_ONE_LOW, RST_ONE_HIGH,
                    RST_MARKER_LOW, RST_MARKER_HIGH, RST_TIMEOUT};
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [15:0] v);
            case (idx)
                REG_ZERO_LOW:    cfg.zero_low_ms    = v;
                REG_ZERO_HIGH:   cfg.zero_high_ms   = v;
                REG_ONE_LOW:     cfg.one_low_ms     = v;
                REG_ONE_HIGH:    cfg.one_high_ms    = v;
                REG_MARKER_LOW:  cfg.marker_low_ms  = v;
                REG_MARKER_HIGH: cfg.marker_high_ms = v;
                REG_TIMEOUT:     cfg.timeout_ticks  = v;
                default: ;
            endcase
        endfunction

        function bit in_win(input logic [15:0] v, lo, hi);
            return v > lo && v < hi;
        endfunction

        function void take_command(input t_in it);
            t_out r;
            int   mi, hr, dy, mo, yr, wd;
            r = '0;
            r.status = ST_NOTHING;
            case (it.op)
                OP_START: begin
                    if (!rx_on) begin
                        rx_on    = 1'b1;
                        ticks    = '0;
                        fill     = '0;
                        r.status = ST_STARTED;
                    end
                end
                OP_TICK: begin
                    if (rx_on) begin
                        if (ticks != TICK_MAX) ticks++;
                        if (ticks >= cfg.timeout_ticks) begin
                            rx_on    = 1'b0;
                            r.status = ST_TIMEOUT;
                        end
                    end
                end
                OP_PULSE: begin
                    if (rx_on) begin
                        // marker wins over one, one over zero
                        if (in_win(it.pulse_ms, cfg.marker_low_ms, cfg.marker_high_ms)) begin
                            bits[0]  = 1'b0;
                            fill     = 6'd1;
                            r.status = ST_MARKER;
                        end else if (in_win(it.pulse_ms, cfg.one_low_ms, cfg.one_high_ms)) begin
                            if (fill < FRAME_LEN) begin
                                bits[fill] = 1'b1;
                                fill++;
                            end
                            r.status = ST_ONE;
                        end else if (in_win(it.pulse_ms, cfg.zero_low_ms, cfg.zero_high_ms)) begin
                            if (fill < FRAME_LEN) begin
                                bits[fill] = 1'b0;
                                fill++;
                            end
                            r.status = ST_ZERO;
                        end else begin
                            rx_on    = 1'b0;
                            r.status = ST_BAD;
                        end
                        if (rx_on && fill >= FRAME_LEN) begin
                            rx_on = 1'b0;
                            if (^bits[28:21] || ^bits[35:29] || ^bits[58:36]) begin
                                r.status = ST_PARITY;
                            end else begin
                                mi = bits[24:21] + 10 * bits[27:25];
                                hr = bits[32:29] + 10 * bits[34:33];
                                dy = bits[39:36] + 10 * bits[41:40];
                                wd = bits[44:42];
                                mo = bits[48:45] + 10 * bits[49];
                                yr = bits[53:50] + 10 * bits[57:54];
                                if (mi > 59 || hr > 23 || dy > 31 || mo > 12 || wd < 1 || wd > 7) begin
                                    r.status = ST_RANGE;
                                end else begin
                                    r.status  = ST_OK;
                                    r.minute  = 6'(mi);
                                    r.hour    = 5'(hr);
                                    r.day     = 5'(dy);
                                    r.month   = 4'(mo);
                                    r.year    = 8'(yr);
                                    r.weekday = 3'(wd);
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.receiving = rx_on;
            r.bit_count = fill;
            status_seen[r.status]++;
            awaited_reports.push_back(r);
        endfunction

        task flag_mismatch(input string what, input int got, input int want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch at result %0d: %s is %0d, expected %0d",
                         reports_seen, what, got, want);
        endtask

        task match_report(input t_out got);
            t_out want;
            reports_seen++;
            if (awaited_reports.size() == 0) begin
                flag_mismatch("status of an unawaited result", got.status, -1);
            end else begin
                want = awaited_reports.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", got.status, want.status);
                if (got.receiving !== want.receiving)
                    flag_mismatch("receiving", got.receiving, want.receiving);
                if (got.bit_count !== want.bit_count)
                    flag_mismatch("bit_count", got.bit_count, want.bit_count);
                if (got.minute !== want.minute)
                    flag_mismatch("minute", got.minute, want.minute);
                if (got.hour !== want.hour)
                    flag_mismatch("hour", got.hour, want.hour);
                if (got.day !== want.day)
                    flag_mismatch("day", got.day, want.day);
                if (got.month !== want.month)
                    flag_mismatch("month", got.month, want.month);
                if (got.year !== want.year)
                    flag_mismatch("year", got.year, want.year);
                if (got.weekday !== want.weekday)
                    flag_mismatch("weekday", got.weekday, want.weekday);
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_in               i_data  = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_out              o_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bit                no_gaps;
    int                sent_items;
    int                frames_sent;
    int                settings_used = 1;
    int                cycle_count;
    t_frame_scoreboard tracker;

    dcf77_time_code_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_LOW);
        i_clk = 1'b1;
        #(CLK_HIGH);
    end

    always @(negedge i_clk) begin
        i_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end

    // check the outgoing item first, then note the incoming one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) tracker.match_report(o_data);
            if (i_valid && !o_stall) tracker.take_command(i_data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d results still awaited",
                     cycle_count, tracker.awaited_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_command(input logic [1:0] cmd_op, input logic [15:0] width);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{cmd_op, width};
        do @(posedge i_clk); while (o_stall);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.awaited_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        drain();
        apb_write(REG_ZERO_LOW,    c.zero_low_ms);
        apb_write(REG_ZERO_HIGH,   c.zero_high_ms);
        apb_write(REG_ONE_LOW,     c.one_low_ms);
        apb_write(REG_ONE_HIGH,    c.one_high_ms);
        apb_write(REG_MARKER_LOW,  c.marker_low_ms);
        apb_write(REG_MARKER_HIGH, c.marker_high_ms);
        apb_write(REG_TIMEOUT,     c.timeout_ticks);
        settings_used++;
    endtask

    // pick a width inside an open window, its edges now and then
    function automatic logic [15:0] pulse_in(input logic [15:0] lo, input logic [15:0] hi);
        int r;
        r = $urandom_range(9);
        if (int'(hi) <= int'(lo) + 1) return 16'($urandom);
        if (r == 0) return lo + 16'd1;
        if (r == 1) return hi - 16'd1;
        return 16'($urandom_range(int'(hi) - 1, int'(lo) + 1));
    endfunction

    task automatic send_noise();
        int          r;
        logic [15:0] w;
        logic [15:0] bounds [6];
        r = $urandom_range(99);
        w = 16'($urandom);
        bounds = '{tracker.cfg.zero_low_ms, tracker.cfg.zero_high_ms,
                   tracker.cfg.one_low_ms, tracker.cfg.one_high_ms,
                   tracker.cfg.marker_low_ms, tracker.cfg.marker_high_ms};
        if ($urandom_range(1)) w = bounds[$urandom_range(5)] + 16'($urandom_range(2)) - 16'd1;
        if (r < 35)      send_command(OP_START, w);
        else if (r < 60) send_command(OP_TICK, w);
        else if (r < 95) send_command(OP_PULSE, w);
        else             send_command(OP_UNUSED, w);
    endtask

    task automatic send_bit(input bit b, input int tick_pct);
        if ($urandom_range(99) < tick_pct) send_command(OP_TICK, 16'($urandom));
        if ($urandom_range(199) == 0) send_noise();
        if (b) send_command(OP_PULSE, pulse_in(tracker.cfg.one_low_ms, tracker.cfg.one_high_ms));
        else   send_command(OP_PULSE, pulse_in(tracker.cfg.zero_low_ms, tracker.cfg.zero_high_ms));
    endtask

    task automatic send_frame(input t_frame_kind kind, input int tick_pct);
        bit [FRAME_LEN-1:0] fr;
        int                 mi, hr, dy, wd, mo, yr, lead, k;
        fr = 60'({$urandom, $urandom});
        if (kind != FRAME_RAW) begin
            mi = $urandom_range(59);
            hr = $urandom_range(23);
            dy = $urandom_range(31, 1);
            wd = $urandom_range(7, 1);
            mo = $urandom_range(12, 1);
            yr = $urandom_range(99);
            if (kind == FRAME_RANGE) begin
                case ($urandom_range(4))
                    0:       mi = $urandom_range(79, 60);
                    1:       hr = $urandom_range(39, 24);
                    2:       dy = $urandom_range(39, 32);
                    3:       mo = $urandom_range(19, 13);
                    default: wd = 0;
                endcase
            end
            fr[24:21] = 4'(mi % 10);
            fr[27:25] = 3'(mi / 10);
            fr[32:29] = 4'(hr % 10);
            fr[34:33] = 2'(hr / 10);
            fr[39:36] = 4'(dy % 10);
            fr[41:40] = 2'(dy / 10);
            fr[44:42] = 3'(wd);
            fr[48:45] = 4'(mo % 10);
            fr[49]    = 1'(mo / 10);
            fr[53:50] = 4'(yr % 10);
            fr[57:54] = 4'(yr / 10);
        end
        fr[28] = ^fr[27:21];
        fr[35] = ^fr[34:29];
        fr[58] = ^fr[57:36];
        // one flipped bit breaks exactly one parity group
        if (kind == FRAME_PARITY) begin
            k = $urandom_range(58, 21);
            fr[k] = ~fr[k];
        end
        send_command(OP_START, 16'($urandom));
        // stray bits ahead of the marker get overwritten by the restart
        lead = ($urandom_range(9) == 0) ? $urandom_range(5, 1) : 0;
        repeat (lead) send_bit($urandom_range(1), tick_pct);
        send_command(OP_PULSE, pulse_in(tracker.cfg.marker_low_ms, tracker.cfg.marker_high_ms));
        for (int i = 1; i < FRAME_LEN; i++) send_bit(fr[i], tick_pct);
        frames_sent++;
    endtask

    task automatic run_phase(input int budget, input int frame_pct, input int tick_pct);
        int          stop_at;
        int          r;
        t_frame_kind kind;
        stop_at = sent_items + budget;
        while (sent_items < stop_at) begin
            if ($urandom_range(99) < frame_pct) begin
                r = $urandom_range(99);
                if (frames_sent < 4)  kind = t_frame_kind'(frames_sent);
                else if (r < 55)      kind = FRAME_GOOD;
                else if (r < 70)      kind = FRAME_PARITY;
                else if (r < 85)      kind = FRAME_RANGE;
                else                  kind = FRAME_RAW;
                send_frame(kind, tick_pct);
            end else begin
                repeat ($urandom_range(5, 1)) send_noise();
            end
        end
    endtask

    initial begin
        t_cfg c;
        int   v[$];
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset windows: ignored items, window edges, aborts
        send_command(OP_TICK, 16'd0);
        send_command(OP_PULSE, RST_MARKER_LOW + 16'd50);
        send_command(OP_UNUSED, 16'hFFFF);
        send_command(OP_START, 16'd0);
        send_command(OP_START, 16'hFFFF);
        send_command(OP_PULSE, RST_ZERO_LOW + 16'd30);
        send_command(OP_PULSE, RST_ONE_LOW + 16'd30);
        send_command(OP_PULSE, RST_MARKER_LOW + 16'd50);
        send_command(OP_PULSE, RST_ZERO_LOW + 16'd1);
        send_command(OP_PULSE, RST_ZERO_LOW);
        send_command(OP_START, 16'd0);
        send_command(OP_PULSE, RST_ZERO_HIGH - 16'd1);
        send_command(OP_PULSE, RST_ZERO_HIGH);
        send_command(OP_START, 16'd0);
        send_command(OP_PULSE, RST_ONE_LOW + 16'd1);
        send_command(OP_PULSE, RST_ONE_HIGH - 16'd1);
        send_command(OP_PULSE, RST_MARKER_LOW + 16'd1);
        send_command(OP_PULSE, RST_MARKER_HIGH - 16'd1);
        send_command(OP_PULSE, RST_MARKER_HIGH);
        send_command(OP_START, 16'd0);
        send_command(OP_PULSE, 16'd0);
        send_command(OP_START, 16'd0);
        send_command(OP_PULSE, 16'hFFFF);

        run_phase(130, 90, 3);
        // hold the sender until the decoder has caught up
        drain();
        run_phase(130, 90, 3);

        c = '{16'd0, 16'd1000, 16'd1000, 16'd2000, 16'd2000, 16'hFFFF, 16'hFFFF};
        apply_settings(c);
        no_gaps = 1'b1;
        run_phase(160, 90, 3);
        no_gaps = 1'b0;

        repeat (6) v.push_back($urandom_range(65535));
        v.sort();
        c = '{16'(v[0]), 16'(v[1]), 16'(v[2]), 16'(v[3]), 16'(v[4]), 16'(v[5]),
              16'($urandom_range(40, 1))};
        apply_settings(c);
        run_phase(180, 85, 15);

        // overlapping windows exercise the classification order
        c = '{16'd50, 16'd600, 16'd100, 16'd400, 16'd300, 16'd500, RST_TIMEOUT};
        apply_settings(c);
        run_phase(50, 60, 3);

        c = '1;
        apply_settings(c);
        run_phase(30, 0, 0);

        // zero limit aborts on the first tick
        c = '0;
        apply_settings(c);
        run_phase(30, 0, 0);

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (tracker.awaited_reports.size() != 0)
            tracker.flag_mismatch("results left awaited", tracker.awaited_reports.size(), 0);

        $display("run covered %0d items, %0d frames, %0d register settings, %0d results",
                 sent_items, frames_sent, settings_used, tracker.reports_seen);
        $display("decoded %0d, parity errors %0d, range errors %0d, timeouts %0d, bad pulses %0d",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_PARITY],
                 tracker.status_seen[ST_RANGE], tracker.status_seen[ST_TIMEOUT],
                 tracker.status_seen[ST_BAD]);
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/dcf_pkg.sv
sv/dcf_front.sv
sv/dcf_queue.sv
sv/dcf_back.sv
sv/dcf77_time_code_decoder.sv
bench/dcf77_time_code_decoder_tb.sv
